// ----- hw/rtl/lowest_common_ancestor_engine_unit_defines.svh -----
// Assertion macros shared by the lowest common ancestor engine RTL.
`ifndef LOWEST_COMMON_ANCESTOR_ENGINE_UNIT_DEFINES_SVH
`define LOWEST_COMMON_ANCESTOR_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define LCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lca assertion failed");
`define LCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lca assertion failed");
`else
`define LCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/lca_pkg.sv -----
// Types, constants and control codes of the lowest common ancestor engine.
package lca_pkg;

    localparam int NODE_W     = 10;
    localparam int MAX_NODES  = 1 << NODE_W;
    localparam int LOG_LEVELS = 10;
    localparam int DEPTH_W    = 10;
    localparam int FUNC_W     = 2;
    localparam int LVL_W      = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // One ancestor entry: a node number, or the none mark.
    typedef struct packed {
        logic              none;
        logic [NODE_W-1:0] node;
    } t_anc;

    // One table row: the node's depth and its power-of-two ancestors.
    typedef struct packed {
        logic [DEPTH_W-1:0]    depth;
        t_anc [LOG_LEVELS-1:0] anc;
    } t_row;

    localparam t_anc ANC_NONE  = '{none: 1'b1, node: '0};
    localparam t_row ROW_RESET = '{depth: '0, anc: {LOG_LEVELS{ANC_NONE}}};

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_INS_RD,
        S_INS_BASE,
        S_INS_ISSUE,
        S_INS_FILL,
        S_INS_WR,
        S_Q_RD,
        S_Q_LOAD,
        S_C1_ISSUE,
        S_C1_TAKE,
        S_CMP,
        S_C2_ISSUE,
        S_C2_TAKE,
        S_OUT_NODE,
        S_OUT_ROW
    } t_state;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLR_STEP,
        OP_LOAD,
        OP_INS_RD,
        OP_INS_BASE,
        OP_INS_ISSUE,
        OP_INS_FILL,
        OP_INS_WR,
        OP_Q_RD,
        OP_Q_LOAD,
        OP_C1_ISSUE,
        OP_C1_TAKE,
        OP_C2_ISSUE,
        OP_C2_TAKE,
        OP_OUT_NODE,
        OP_OUT_ROW
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   lvl_top;
        logic   lvl_one;
        logic   lvl_inc;
        logic   lvl_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic has_parent;
        logic prev_none;
        logic prev_self;
        logic c1_none;
        logic nodes_eq;
        logic c2_move;
        logic lvl_last;
        logic lvl_zero;
    } t_dp_sts;

endpackage

// ----- hw/rtl/lca_if.sv -----
// Request and result channel interfaces of the lowest common ancestor engine.
interface lca_in_if import lca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic              has_parent;

    modport source (output valid, func, first_node, second_node, has_parent, input ready);
    modport sink (input valid, func, first_node, second_node, has_parent, output ready);
endinterface

interface lca_out_if import lca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] ancestor;
    logic              no_ancestor;

    modport source (output valid, ancestor, no_ancestor, input ready);
    modport sink (input valid, ancestor, no_ancestor, output ready);
endinterface

// ----- hw/rtl/lca_dp.sv -----
// Datapath of the lowest common ancestor engine: row memory, node and row registers.
module lca_dp import lca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [NODE_W-1:0] i_first_node,
    input  logic [NODE_W-1:0] i_second_node,
    input  logic              i_has_parent,
    output t_dp_sts           o_sts,
    output logic [NODE_W-1:0] o_ancestor,
    output logic              o_no_ancestor
);

    t_row              r_mem [MAX_NODES];
    t_row              r_q0;
    t_row              r_q1;
    t_row              r_rowv;
    t_row              r_rowu;
    t_row              r_new;
    logic [NODE_W-1:0] r_v;
    logic [NODE_W-1:0] r_u;
    logic              r_hp;
    logic [NODE_W-1:0] r_clr;
    logic [LVL_W-1:0]  r_k;
    logic [NODE_W-1:0] r_out_anc;
    logic              r_out_none;

    logic [LVL_W-1:0]  w_km1;
    t_anc              w_a;
    t_anc              w_b;
    t_anc              w_prev;
    t_anc              w_a0;
    logic [NODE_W-1:0] w_rd0;
    logic [NODE_W-1:0] w_rd1;
    logic [DEPTH_W-1:0] w_depth_inc;

    assign w_km1  = r_k - LVL_W'(1);
    assign w_a    = r_rowv.anc[r_k];
    assign w_b    = r_rowu.anc[r_k];
    assign w_prev = r_new.anc[w_km1];
    assign w_a0   = r_rowv.anc[0];
    assign w_depth_inc = (r_q0.depth == DEPTH_MAX) ? DEPTH_MAX : r_q0.depth + DEPTH_W'(1);

    always_comb begin
        w_rd0 = r_v;
        w_rd1 = r_u;
        case (i_cmd.op)
            OP_INS_RD:    w_rd0 = r_u;
            OP_INS_ISSUE: w_rd0 = w_prev.node;
            OP_C1_ISSUE:  w_rd0 = w_a.node;
            OP_C2_ISSUE: begin
                w_rd0 = w_a.node;
                w_rd1 = w_b.node;
            end
            default: ;
        endcase
    end

    // Both read ports run every cycle; each result is consumed in the cycle after its address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLR_STEP) begin
            r_mem[r_clr] <= ROW_RESET;
        end else if (i_cmd.op == OP_INS_WR) begin
            r_mem[r_v] <= r_new;
        end
        r_q0 <= r_mem[w_rd0];
        r_q1 <= r_mem[w_rd1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_k   <= '0;
        end else begin
            if (i_cmd.op == OP_CLR_STEP) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_cmd.lvl_top) begin
                r_k <= LVL_W'(LOG_LEVELS - 1);
            end else if (i_cmd.lvl_one) begin
                r_k <= LVL_W'(1);
            end else if (i_cmd.lvl_inc) begin
                r_k <= r_k + LVL_W'(1);
            end else if (i_cmd.lvl_dec) begin
                r_k <= w_km1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_v   <= i_first_node;
                r_u   <= i_second_node;
                r_hp  <= i_has_parent;
                r_new <= ROW_RESET;
            end
            OP_INS_BASE: begin
                r_new.depth  <= w_depth_inc;
                r_new.anc[0] <= '{none: 1'b0, node: r_u};
            end
            OP_INS_ISSUE: begin
                // A node that is its own ancestor reads its own new row.
                if (!w_prev.none && (w_prev.node == r_v)) begin
                    r_new.anc[r_k] <= '{none: 1'b0, node: r_v};
                end
            end
            OP_INS_FILL: r_new.anc[r_k] <= r_q0.anc[w_km1];
            OP_Q_LOAD: begin
                if (r_q0.depth < r_q1.depth) begin
                    r_v    <= r_u;
                    r_u    <= r_v;
                    r_rowv <= r_q1;
                    r_rowu <= r_q0;
                end else begin
                    r_rowv <= r_q0;
                    r_rowu <= r_q1;
                end
            end
            OP_C1_TAKE: begin
                if (r_q0.depth >= r_rowu.depth) begin
                    r_v    <= w_a.node;
                    r_rowv <= r_q0;
                end
            end
            OP_C2_TAKE: begin
                r_v    <= w_a.node;
                r_u    <= w_b.node;
                r_rowv <= r_q0;
                r_rowu <= r_q1;
            end
            OP_OUT_NODE: begin
                r_out_anc  <= r_v;
                r_out_none <= 1'b0;
            end
            OP_OUT_ROW: begin
                r_out_anc  <= w_a0.none ? '0 : w_a0.node;
                r_out_none <= w_a0.none;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.clr_last   = &r_clr;
        o_sts.has_parent = r_hp;
        o_sts.prev_none  = w_prev.none;
        o_sts.prev_self  = (w_prev.node == r_v);
        o_sts.c1_none    = w_a.none;
        o_sts.nodes_eq   = (r_v == r_u);
        o_sts.c2_move    = (w_a != w_b) && !w_a.none && !w_b.none;
        o_sts.lvl_last   = (r_k == LVL_W'(LOG_LEVELS - 1));
        o_sts.lvl_zero   = (r_k == '0);
    end

    assign o_ancestor    = r_out_anc;
    assign o_no_ancestor = r_out_none;

endmodule

// ----- hw/rtl/lca_ctrl.sv -----
// Controller state machine of the lowest common ancestor engine.
module lca_ctrl import lca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_in_func,
    input  logic              i_out_ready,
    input  t_dp_sts           i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_dp_cmd           o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((o_cmd.op == OP_OUT_NODE) || (o_cmd.op == OP_OUT_ROW)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{op: OP_IDLE, lvl_top: 1'b0, lvl_one: 1'b0, lvl_inc: 1'b0, lvl_dec: 1'b0};
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR_STEP;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    case (t_func'(i_in_func))
                        FUNC_INSERT: n_state = S_INS_RD;
                        FUNC_QUERY:  n_state = S_Q_RD;
                        FUNC_CLEAR:  n_state = S_CLR;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: begin
                o_cmd.op = OP_INS_RD;
                n_state  = i_sts.has_parent ? S_INS_BASE : S_INS_WR;
            end
            S_INS_BASE: begin
                o_cmd.op      = OP_INS_BASE;
                o_cmd.lvl_one = 1'b1;
                n_state       = (LOG_LEVELS > 1) ? S_INS_ISSUE : S_INS_WR;
            end
            S_INS_ISSUE: begin
                o_cmd.op = OP_INS_ISSUE;
                // Once a level has no ancestor, every higher level has none either.
                if (i_sts.prev_none) begin
                    n_state = S_INS_WR;
                end else if (i_sts.prev_self) begin
                    if (i_sts.lvl_last) begin
                        n_state = S_INS_WR;
                    end else begin
                        o_cmd.lvl_inc = 1'b1;
                    end
                end else begin
                    n_state = S_INS_FILL;
                end
            end
            S_INS_FILL: begin
                o_cmd.op = OP_INS_FILL;
                if (i_sts.lvl_last) begin
                    n_state = S_INS_WR;
                end else begin
                    o_cmd.lvl_inc = 1'b1;
                    n_state       = S_INS_ISSUE;
                end
            end
            S_INS_WR: begin
                o_cmd.op = OP_INS_WR;
                n_state  = S_IDLE;
            end
            S_Q_RD: begin
                o_cmd.op = OP_Q_RD;
                n_state  = S_Q_LOAD;
            end
            S_Q_LOAD: begin
                o_cmd.op      = OP_Q_LOAD;
                o_cmd.lvl_top = 1'b1;
                n_state       = S_C1_ISSUE;
            end
            S_C1_ISSUE: begin
                o_cmd.op = OP_C1_ISSUE;
                if (!i_sts.c1_none) begin
                    n_state = S_C1_TAKE;
                end else if (i_sts.lvl_zero) begin
                    n_state = S_CMP;
                end else begin
                    o_cmd.lvl_dec = 1'b1;
                end
            end
            S_C1_TAKE: begin
                o_cmd.op = OP_C1_TAKE;
                if (i_sts.lvl_zero) begin
                    n_state = S_CMP;
                end else begin
                    o_cmd.lvl_dec = 1'b1;
                    n_state       = S_C1_ISSUE;
                end
            end
            S_CMP: begin
                if (i_sts.nodes_eq) begin
                    n_state = S_OUT_NODE;
                end else begin
                    o_cmd.lvl_top = 1'b1;
                    n_state       = S_C2_ISSUE;
                end
            end
            S_C2_ISSUE: begin
                o_cmd.op = OP_C2_ISSUE;
                if (i_sts.c2_move) begin
                    n_state = S_C2_TAKE;
                end else if (i_sts.lvl_zero) begin
                    n_state = S_OUT_ROW;
                end else begin
                    o_cmd.lvl_dec = 1'b1;
                end
            end
            S_C2_TAKE: begin
                o_cmd.op = OP_C2_TAKE;
                if (i_sts.lvl_zero) begin
                    n_state = S_OUT_ROW;
                end else begin
                    o_cmd.lvl_dec = 1'b1;
                    n_state       = S_C2_ISSUE;
                end
            end
            S_OUT_NODE: begin
                if (w_out_free) begin
                    o_cmd.op = OP_OUT_NODE;
                    n_state  = S_IDLE;
                end
            end
            S_OUT_ROW: begin
                if (w_out_free) begin
                    o_cmd.op = OP_OUT_ROW;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/lowest_common_ancestor_engine_unit.sv -----
// Top level of the binary-lifting lowest common ancestor engine.
// Each node owns one row in a 1024-entry memory that holds its depth and its ten
// power-of-two ancestors; all timing follows from that memory's registered read.
// After reset, and after every clear transaction, the engine sweeps all 1024 rows
// of the memory, one row per cycle, and takes no request meanwhile. An insert
// accepts the request and reads the parent's row; for a root the row is then written,
// while with a parent each of the nine upper levels that has an ancestor takes an
// issue and, where needed, a fill step before the row write. A query reads and orders
// both rows, then climbs: the first climb always visits all ten levels, the second
// runs only when the nodes differ after the first, and in each climb a level takes an
// issue and a take step where a lift is tried and only an issue step where it is
// skipped. Requests are handled one at a time; a finished result waits in the output
// register while the next request is already taken. Only queries return a result; func value 3 is dropped.
`include "lowest_common_ancestor_engine_unit_defines.svh"

module lowest_common_ancestor_engine_unit import lca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lca_in_if.sink     i_in,
    lca_out_if.source  o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.func),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    lca_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_first_node  (i_in.first_node),
        .i_second_node (i_in.second_node),
        .i_has_parent  (i_in.has_parent),
        .o_sts         (w_sts),
        .o_ancestor    (o_out.ancestor),
        .o_no_ancestor (o_out.no_ancestor)
    );

    `LCA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.func != FUNC_NONE), !i_in.ready)
    `LCA_ASSERT_IMP(a_out_from_load, i_clk, i_rst_n, $rose(o_out.valid), $past(w_cmd.op == OP_OUT_NODE || w_cmd.op == OP_OUT_ROW))
    `LCA_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, w_cmd.op == OP_CLR_STEP, !i_in.ready)

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the binary-lifting lowest common ancestor engine.
module tb import lca_pkg::*; ();

    localparam int LIMIT_CYCLES = 600000;
    localparam int RAND_ITEMS   = 520;
    localparam int CHAIN_ITEMS  = 104;
    localparam int IDLE_PCT     = 21;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int DIR_N        = 23;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              no_ancestor;
    } t_answer;

    typedef struct packed {
        t_func             func;
        logic [NODE_W-1:0] first_node;
        logic [NODE_W-1:0] second_node;
        logic              has_parent;
        logic              typed;
        t_answer           answer;
    } t_step;

    // Opening sequence; typed answers hold where the tree is trivial to read.
    localparam t_step DIRECTED [0:DIR_N-1] = '{
        '{FUNC_QUERY,  10'd0,    10'd1023, 1'b0, 1'b1, '{10'd0,    1'b1}},
        '{FUNC_QUERY,  10'd5,    10'd5,    1'b0, 1'b1, '{10'd5,    1'b0}},
        '{FUNC_INSERT, 10'd0,    10'd0,    1'b0, 1'b0, '0},
        '{FUNC_INSERT, 10'd1023, 10'd0,    1'b1, 1'b0, '0},
        '{FUNC_INSERT, 10'd512,  10'd1023, 1'b1, 1'b0, '0},
        '{FUNC_INSERT, 10'd341,  10'd1023, 1'b1, 1'b0, '0},
        '{FUNC_QUERY,  10'd512,  10'd341,  1'b0, 1'b1, '{10'd1023, 1'b0}},
        '{FUNC_QUERY,  10'd512,  10'd0,    1'b0, 1'b1, '{10'd0,    1'b0}},
        '{FUNC_QUERY,  10'd1023, 10'd1023, 1'b0, 1'b1, '{10'd1023, 1'b0}},
        '{FUNC_INSERT, 10'd682,  10'd5,    1'b1, 1'b0, '0},
        '{FUNC_QUERY,  10'd682,  10'd512,  1'b0, 1'b1, '{10'd0,    1'b1}},
        '{FUNC_INSERT, 10'd7,    10'd7,    1'b1, 1'b0, '0},
        '{FUNC_QUERY,  10'd7,    10'd0,    1'b0, 1'b0, '0},
        '{FUNC_INSERT, 10'd0,    10'd512,  1'b1, 1'b0, '0},
        '{FUNC_QUERY,  10'd341,  10'd0,    1'b0, 1'b0, '0},
        '{FUNC_INSERT, 10'd1023, 10'd1023, 1'b0, 1'b0, '0},
        '{FUNC_QUERY,  10'd512,  10'd341,  1'b0, 1'b0, '0},
        '{FUNC_NONE,   10'd1023, 10'd1023, 1'b1, 1'b0, '0},
        '{FUNC_QUERY,  10'd1023, 10'd512,  1'b1, 1'b0, '0},
        '{FUNC_CLEAR,  10'd1023, 10'd1023, 1'b1, 1'b0, '0},
        '{FUNC_QUERY,  10'd512,  10'd341,  1'b0, 1'b1, '{10'd0,    1'b1}},
        '{FUNC_INSERT, 10'd1,    10'd1023, 1'b0, 1'b0, '0},
        '{FUNC_QUERY,  10'd1,    10'd1,    1'b0, 1'b1, '{10'd1,    1'b0}}
    };

    logic i_clk;
    logic i_rst_n;

    lca_in_if  in_ch();
    lca_out_if out_ch();

    lowest_common_ancestor_engine_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Mirror of the engine's tables.
    t_anc              anc_rows   [MAX_NODES][LOG_LEVELS];
    logic [DEPTH_W-1:0] node_depth [MAX_NODES];

    t_answer           answer_q[$];
    logic [NODE_W-1:0] live_nodes[$];
    logic [NODE_W-1:0] newest_node;
    int                errors;
    int                n_accepted;
    int                cycle_cnt;
    int                hold_left;
    bit                hold_done;
    bit                quiet;

    function automatic void wipe_tree();
        for (int n = 0; n < MAX_NODES; n++) begin
            node_depth[n] = '0;
            for (int k = 0; k < LOG_LEVELS; k++) begin
                anc_rows[n][k] = ANC_NONE;
            end
        end
    endfunction

    function automatic void insert_node(logic [NODE_W-1:0] v, logic [NODE_W-1:0] p, logic hp);
        int   d;
        t_anc prev;
        if (!hp) begin
            node_depth[v] = '0;
            for (int k = 0; k < LOG_LEVELS; k++) begin
                anc_rows[v][k] = ANC_NONE;
            end
        end else begin
            d = int'(node_depth[p]) + 1;
            if (d > int'(DEPTH_MAX)) begin
                d = int'(DEPTH_MAX);
            end
            node_depth[v] = DEPTH_W'(d);
            anc_rows[v][0] = '{none: 1'b0, node: p};
            // The row is updated in place, so a self parent reads its fresh entries.
            for (int k = 1; k < LOG_LEVELS; k++) begin
                prev = anc_rows[v][k-1];
                anc_rows[v][k] = prev.none ? ANC_NONE : anc_rows[prev.node][k-1];
            end
        end
    endfunction

    function automatic t_answer common_ancestor(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] v;
        logic [NODE_W-1:0] u;
        t_anc              x;
        t_anc              y;
        v = a;
        u = b;
        if (node_depth[v] < node_depth[u]) begin
            v = b;
            u = a;
        end
        for (int k = LOG_LEVELS - 1; k >= 0; k--) begin
            x = anc_rows[v][k];
            if (!x.none && node_depth[x.node] >= node_depth[u]) begin
                v = x.node;
            end
        end
        if (v == u) begin
            return '{ancestor: v, no_ancestor: 1'b0};
        end
        for (int k = LOG_LEVELS - 1; k >= 0; k--) begin
            x = anc_rows[v][k];
            y = anc_rows[u][k];
            if (x != y && !x.none && !y.none) begin
                v = x.node;
                u = y.node;
            end
        end
        x = anc_rows[v][0];
        if (x.none) begin
            return '{ancestor: '0, no_ancestor: 1'b1};
        end
        return '{ancestor: x.node, no_ancestor: 1'b0};
    endfunction

    function automatic logic [NODE_W-1:0] any_live();
        return live_nodes[$urandom_range(live_nodes.size() - 1)];
    endfunction

    // Offers one transaction with random idle cycles ahead of it and updates the mirror
    // once the engine takes it.
    task automatic send_step(t_step s);
        t_answer ans;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= s.func;
        in_ch.first_node  <= s.first_node;
        in_ch.second_node <= s.second_node;
        in_ch.has_parent  <= s.has_parent;
        do @(posedge i_clk); while (!in_ch.ready);
        n_accepted++;
        case (s.func)
            FUNC_INSERT: insert_node(s.first_node, s.second_node, s.has_parent);
            FUNC_CLEAR:  wipe_tree();
            FUNC_QUERY: begin
                ans = common_ancestor(s.first_node, s.second_node);
                answer_q = {answer_q, (s.typed ? s.answer : ans)};
            end
            default: ;
        endcase
    endtask

    // Mostly grows trees by well-formed inserts and queries their nodes; a smaller
    // share is self and cyclic parents, unknown parents, dropped codes and clears.
    task automatic pick_random(output t_step s);
        int r;
        r = $urandom_range(999);
        s.typed       = 1'b0;
        s.answer      = '0;
        s.func        = FUNC_NONE;
        s.first_node  = NODE_W'($urandom_range(MAX_NODES - 1));
        s.second_node = NODE_W'($urandom_range(MAX_NODES - 1));
        s.has_parent  = 1'($urandom_range(1));
        if (live_nodes.size() == 0) begin
            s.func = FUNC_INSERT;
            s.has_parent = 1'b0;
            live_nodes = {live_nodes, s.first_node};
            newest_node = s.first_node;
        end else if (r < 8) begin
            s.func = FUNC_CLEAR;
            live_nodes.delete();
        end else if (r < 450) begin
            s.func = FUNC_QUERY;
            s.first_node = any_live();
            if (r >= 60) begin
                s.second_node = any_live();
            end
        end else if (r < 880) begin
            s.func = FUNC_INSERT;
            s.has_parent = (r < 860);
            s.second_node = (r < 650) ? newest_node : any_live();
            live_nodes = {live_nodes, s.first_node};
            newest_node = s.first_node;
        end else if (r < 920) begin
            s.func = FUNC_INSERT;
            s.first_node = any_live();
            s.second_node = s.first_node;
            s.has_parent = 1'b1;
        end else if (r < 960) begin
            s.func = FUNC_INSERT;
            s.has_parent = 1'b1;
            live_nodes = {live_nodes, s.first_node};
        end else if (r < 985) begin
            s.func = FUNC_INSERT;
            s.first_node = any_live();
            s.second_node = any_live();
            s.has_parent = 1'b1;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: checks each query result and drives ready, including
    // one long hold-off that backs the engine up into its input.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (answer_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, got ancestor %0d no_ancestor %0b",
                             $time, out_ch.ancestor, out_ch.no_ancestor);
                end else begin
                    if (out_ch.ancestor !== answer_q[0].ancestor) begin
                        errors++;
                        $display("%0t: ancestor mismatch, expected %0d, got %0d",
                                 $time, answer_q[0].ancestor, out_ch.ancestor);
                    end
                    if (out_ch.no_ancestor !== answer_q[0].no_ancestor) begin
                        errors++;
                        $display("%0t: no_ancestor mismatch, expected %0b, got %0b",
                                 $time, answer_q[0].no_ancestor, out_ch.no_ancestor);
                    end
                    void'(answer_q.pop_front());
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            out_ch.ready <= i_rst_n && (hold_left == 0)
                            && (quiet || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        t_step             s;
        logic [NODE_W-1:0] chain_node;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= FUNC_NONE;
        in_ch.first_node  <= '0;
        in_ch.second_node <= '0;
        in_ch.has_parent  <= 1'b0;
        wipe_tree();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            send_step(DIRECTED[i]);
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            quiet = (i >= 250 && i < 370);
            if (i == 450) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (answer_q.size() != 0);
            end
            pick_random(s);
            send_step(s);
        end

        // A node hung under itself gains one level per insert.
        chain_node = NODE_W'($urandom_range(MAX_NODES - 1));
        s = '{FUNC_INSERT, chain_node, chain_node, 1'b0, 1'b0, '0};
        send_step(s);
        for (int i = 0; i < CHAIN_ITEMS; i++) begin
            s.has_parent = 1'b1;
            if (i % 64 == 63) begin
                s.func = FUNC_QUERY;
                s.second_node = NODE_W'($urandom_range(MAX_NODES - 1));
            end else begin
                s.func = FUNC_INSERT;
                s.second_node = chain_node;
            end
            send_step(s);
        end
        s = '{FUNC_INSERT, ~chain_node, chain_node, 1'b1, 1'b0, '0};
        send_step(s);
        s = '{FUNC_QUERY, ~chain_node, chain_node, 1'b0, 1'b1, '{chain_node, 1'b0}};
        send_step(s);
        s = '{FUNC_QUERY, chain_node, ~chain_node, 1'b0, 1'b0, '0};
        send_step(s);

        in_ch.valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
